// ===== rtl/lpfp_pkg.sv =====
// Shared types and constants for the length-prefixed frame parser.
package lpfp_pkg;

    localparam int unsigned MIN_FRAME = 8;
    localparam int unsigned HDR_BYTES = 4;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_STREAMS = 1'b0;
    localparam logic REG_MAX_FRAME   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_STREAM = 2'd1,
        ST_BAD_HDR    = 2'd2,
        ST_TOO_LONG   = 2'd3
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] count;
        logic [31:0] remaining;
        logic [23:0] header;
    } t_entry;

endpackage

// ===== rtl/lpfp_state_ram.sv =====
// Per-stream state memory: one write port, one read port with registered data.
module lpfp_state_ram #(
    parameter int AW = 3,
    parameter int DW = 74
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read-before-write; the caller bypasses same-entry collisions
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/length_prefixed_frame_parser.sv =====
// Top level: multi-stream length-prefixed frame parser.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_stream_index, i_data_byte
//  out     | output    | o_out_valid / i_out_stall | o_stream_out, o_byte_out, o_is_body,
//          |           |                           | o_frame_end, o_frame_length, o_status
//  cfg     | input     | APB (psel/penable/pready) | reg 0 num_streams @0, reg 1 max len @4
//
// One byte per cycle sustained unless the output stalls; each result is registered.
// Read: the stream's state entry is read from the state RAM (registered read).
// Update: the entry is updated and written back; a one-entry bypass register covers
//         a write to the same stream landing on the edge its read was issued.
// Reset clears control state only; a valid bit per stream makes an unwritten entry
// read as idle, so there is no clearing pass.
// A stalled output holds its result; the input stalls only when the update stage is
// full and cannot drain into the output register.
module length_prefixed_frame_parser
    import lpfp_pkg::*;
#(
    parameter int STREAMS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_stream_index,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_stream_out,
    output logic [7:0]  o_byte_out,
    output logic        o_is_body,
    output logic        o_frame_end,
    output logic [15:0] o_frame_length,
    output logic [1:0]  o_status,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int          AW        = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int          DEPTH     = 2 ** AW;
    localparam int          DW        = $bits(t_entry);
    localparam logic [4:0]  STREAMS_W = 5'(STREAMS);
    localparam logic [3:0]  NUM_RST   = (STREAMS < 8) ? 4'(STREAMS) : 4'd8;
    localparam logic [15:0] MAX_RST   = 16'd2048;
    localparam logic [15:0] MIN_W     = 16'(MIN_FRAME);
    localparam logic [31:0] HDR_W     = 32'(HDR_BYTES);

    localparam t_entry ENTRY_RST = '{phase: PH_IDLE, count: '0, remaining: '0, header: '0};

    // ---------------- configuration registers ----------------
    logic [3:0]  r_num_streams;
    logic [15:0] r_max_len;
    logic        cfg_wr;
    logic [3:0]  n_num_streams;
    logic [15:0] n_max_len;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // clamp and saturate the written values
    assign n_num_streams = ({1'b0, pwdata[3:0]} > STREAMS_W) ? STREAMS_W[3:0] : pwdata[3:0];
    assign n_max_len     = (pwdata[15:0] < MIN_W) ? MIN_W : pwdata[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_streams <= NUM_RST;
            r_max_len     <= MAX_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_NUM_STREAMS: r_num_streams <= n_num_streams;
                REG_MAX_FRAME:   r_max_len     <= n_max_len;
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NUM_STREAMS: prdata = {28'd0, r_num_streams};
            REG_MAX_FRAME:   prdata = {16'd0, r_max_len};
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic          r_s1_valid;
    logic [3:0]    r_s1_stream;
    logic [7:0]    r_s1_byte;
    logic          r_out_valid;
    logic          in_xfer;
    logic          s1_adv;
    logic          wr_en;
    logic [AW-1:0] s1_addr;

    assign s1_adv     = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;
    assign s1_addr    = r_s1_stream[AW-1:0];

    // ---------------- state memory ----------------
    logic [DW-1:0]    ram_q;
    logic [DEPTH-1:0] r_ent_valid;
    logic             r_fwd_valid;
    logic [AW-1:0]    r_fwd_addr;
    t_entry           r_fwd_entry;
    t_entry           cur;
    t_entry           nxt;

    lpfp_state_ram #(
        .AW (AW),
        .DW (DW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (i_stream_index[AW-1:0]),
        .o_rd_data (ram_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (nxt)
    );

    // newest copy of the entry: bypass, then RAM, then reset value
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == s1_addr)) begin
            cur = r_fwd_entry;
        end else if (r_ent_valid[s1_addr]) begin
            cur = t_entry'(ram_q);
        end else begin
            cur = ENTRY_RST;
        end
    end

    // ---------------- entry update ----------------
    logic        oor;
    logic        body;
    logic        fend;
    logic [15:0] flen;
    t_status     status;
    logic [16:0] cnt_inc;
    logic [31:0] rem_dec;
    logic [1:0]  hdr_pos;
    logic [31:0] hdr_len;

    always_comb begin
        oor     = (r_s1_stream >= r_num_streams) || ({1'b0, r_s1_stream} >= STREAMS_W);
        cnt_inc = {1'b0, cur.count} + 17'd1;
        rem_dec = cur.remaining - 32'd1;
        hdr_pos = (cur.phase == PH_HDR) ? cur.count[1:0] : 2'd0;
        hdr_len = {r_s1_byte, cur.header};
        nxt     = cur;
        body    = 1'b0;
        fend    = 1'b0;
        flen    = '0;
        status  = ST_OK;

        if (oor) begin
            status = ST_BAD_STREAM;
        end else if (cur.phase == PH_BODY) begin
            if (cnt_inc > {1'b0, r_max_len}) begin
                status        = ST_TOO_LONG;
                flen          = cur.count;
                nxt.phase     = PH_IDLE;
                nxt.count     = '0;
                nxt.remaining = '0;
            end else begin
                nxt.count     = cnt_inc[15:0];
                nxt.remaining = rem_dec;
                body          = 1'b1;
                flen          = cnt_inc[15:0];
                if (rem_dec == 32'd0) begin
                    fend      = 1'b1;
                    nxt.phase = PH_IDLE;
                end
            end
        end else if (hdr_pos != 2'd3) begin
            // little-endian length bytes 0..2
            nxt.phase = PH_HDR;
            case (hdr_pos)
                2'd0:    nxt.header[7:0]   = r_s1_byte;
                2'd1:    nxt.header[15:8]  = r_s1_byte;
                2'd2:    nxt.header[23:16] = r_s1_byte;
                default: ;
            endcase
            nxt.count = {14'd0, hdr_pos} + 16'd1;
            flen      = {14'd0, hdr_pos} + 16'd1;
        end else begin
            // last length byte completes the header
            flen      = HDR_W[15:0];
            nxt.count = HDR_W[15:0];
            if (hdr_len < 32'(MIN_FRAME)) begin
                status        = ST_BAD_HDR;
                nxt.phase     = PH_IDLE;
                nxt.count     = '0;
                nxt.remaining = '0;
            end else begin
                nxt.remaining = hdr_len - HDR_W;
                if (hdr_len == HDR_W) begin
                    fend      = 1'b1;
                    nxt.phase = PH_IDLE;
                end else begin
                    nxt.phase = PH_BODY;
                end
            end
        end
    end

    assign wr_en = s1_adv & ~oor;

    // ---------------- registers ----------------
    logic [3:0]  r_out_stream;
    logic [7:0]  r_out_byte;
    logic        r_out_body;
    logic        r_out_end;
    logic [15:0] r_out_len;
    t_status     r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_ent_valid <= '0;
        end else begin
            if (in_xfer) begin
                r_s1_valid  <= 1'b1;
                // capture the write landing on the same edge as this read
                r_fwd_valid <= wr_en;
            end else if (s1_adv) begin
                r_s1_valid  <= 1'b0;
            end
            if (wr_en) begin
                r_ent_valid[s1_addr] <= 1'b1;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_stream <= i_stream_index;
            r_s1_byte   <= i_data_byte;
            r_fwd_addr  <= s1_addr;
            r_fwd_entry <= nxt;
        end
        if (s1_adv) begin
            r_out_stream <= r_s1_stream;
            r_out_byte   <= r_s1_byte;
            r_out_body   <= body;
            r_out_end    <= fend;
            r_out_len    <= flen;
            r_out_status <= status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_stream_out   = r_out_stream;
    assign o_byte_out     = r_out_byte;
    assign o_is_body      = r_out_body;
    assign o_frame_end    = r_out_end;
    assign o_frame_length = r_out_len;
    assign o_status       = r_out_status;

endmodule

// ===== rtl/lpfp_checker.sv =====
// Port-level checks for the frame parser, bound to the top level.
module lpfp_checker
    import lpfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_stream_out,
    input logic [7:0]  o_byte_out,
    input logic        o_is_body,
    input logic        o_frame_end,
    input logic [15:0] o_frame_length,
    input logic [1:0]  o_status
);

    // nothing in flight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_out)
            && $stable(o_stream_out) && $stable(o_frame_length) && $stable(o_status))
        else $error("stalled result changed");

    // errors never mark body or frame end
    a_err_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> !o_is_body && !o_frame_end)
        else $error("error result carries body or end flag");

    // bad stream reports zero length; bad header reports the header length
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status != ST_BAD_STREAM) || (o_frame_length == 16'd0))
            && ((o_status != ST_BAD_HDR) || (o_frame_length == 16'(HDR_BYTES))))
        else $error("error result length wrong");

    // a body byte always follows a full header
    a_body_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_body |-> o_frame_length > 16'(HDR_BYTES))
        else $error("body byte inside header length");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);
